// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// same-cycle implication that also holds around reset
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/nsr_pkg.sv
// ----------------------------------------------------------------------------
// NFA recognizer package
// Action codes, transition slot layout and position width.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int POS_W  = 16;
  localparam int CFG_W  = 6;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_FEED  = 2'd2;

  localparam logic [POS_W-1:0] POSITION_MAX = '1;
  localparam logic [CFG_W-1:0] STATES_RESET = 6'd32;

  // one transition slot as stored in a memory row
  typedef struct packed {
    logic       en;
    logic [7:0] sym;
    logic [4:0] tgt;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// File: sv/nsr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module nsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/nfa_string_recognizer.sv
// ----------------------------------------------------------------------------
// NFA string recognizer
// Active-state-set simulation of an NFA; the transition table is kept in a
// RAM with one row per source state holding all of its slots.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  item      | in        | item_valid/item_stall  | action node slot entry_* character
//  result    | out       | result_valid/result_stall | accepted alive position
//  config    | in        | cfg_we                 | cfg_data (states_in_use)
//
// Feed: one RAM row read per cycle for each of the n states in use.
// Load: row read, merge and write back. Start/other: straight to the result.
// After reset a clearing pass writes MAX_STATES rows; items are held off
// until it is done. One item is in work at a time; the next item is
// taken while an earlier result waits under result_stall.
// ----------------------------------------------------------------------------
module nfa_string_recognizer #(
  parameter int MAX_STATES      = 32,
  parameter int SLOTS_PER_STATE = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [nsr_pkg::CFG_W-1:0] cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [1:0]               action,
  input  logic [4:0]               node,
  input  logic [2:0]               slot,
  input  logic [7:0]               entry_symbol,
  input  logic [4:0]               entry_target,
  input  logic                     entry_valid,
  input  logic [7:0]               character,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic                     accepted,
  output logic                     alive,
  output logic [nsr_pkg::POS_W-1:0] position
);

  import nsr_pkg::*;

  localparam int AW    = $clog2(MAX_STATES);
  localparam int NW    = $clog2(MAX_STATES + 1);
  localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int SNW   = $clog2(SLOTS_PER_STATE + 1);
  localparam int SXW   = (SNW > 3) ? SNW : 3;
  localparam int SW    = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
  localparam int NDW   = (NW > 5) ? NW : 5;
  localparam int ROW_W = SLOTS_PER_STATE * ENTRY_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOAD, S_FEED, S_DONE} state_t;

  typedef slot_entry_t [SLOTS_PER_STATE-1:0] row_t;

  state_t                state;
  logic [CFG_W-1:0]      states_in_use;
  logic [MAX_STATES-1:0] active;
  logic [MAX_STATES-1:0] acc;
  logic [POS_W-1:0]      char_count;
  logic [AW-1:0]         clr_idx;
  logic [CW-1:0]         feed_idx;
  logic                  pend;
  logic [AW-1:0]         pend_idx;
  logic [AW-1:0]         node_r;
  logic [SW-1:0]         slot_r;
  slot_entry_t           entry_r;
  logic [7:0]            char_r;

  logic [CW-1:0]         cfg_ext;
  logic [CW-1:0]         n_used;
  logic [CW-1:0]         n_last;
  logic [MAX_STATES-1:0] used_mask;
  logic [MAX_STATES-1:0] live;
  logic [NDW-1:0]        node_ext;
  logic [SXW-1:0]        slot_ext;
  logic                  load_ok;
  logic                  take;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ROW_W-1:0]      ram_rdata;
  row_t                  row_rd;
  row_t                  row_wr;
  logic [MAX_STATES-1:0] row_hit;

  // clamp the register: 0 acts as 1, above MAX_STATES acts as MAX_STATES
  assign cfg_ext = CW'(states_in_use);
  always_comb begin
    if (cfg_ext == '0) begin
      n_used = CW'(1);
    end else if (cfg_ext > CW'(MAX_STATES)) begin
      n_used = CW'(MAX_STATES);
    end else begin
      n_used = cfg_ext;
    end
  end
  assign n_last = n_used - CW'(1);

  always_comb begin
    for (int j = 0; j < MAX_STATES; j++) begin
      used_mask[j] = (CW'(j) < n_used);
    end
  end
  assign live = active & used_mask;

  assign node_ext = NDW'(node);
  assign slot_ext = SXW'(slot);
  assign load_ok  = (node_ext < NDW'(MAX_STATES)) && (slot_ext < SXW'(SLOTS_PER_STATE));

  assign item_stall = (state != S_IDLE);
  assign take       = item_valid && !item_stall;

  assign row_rd = ram_rdata;

  always_comb begin
    row_wr         = row_rd;
    row_wr[slot_r] = entry_r;
  end

  // moves out of one active state for the current character
  always_comb begin
    logic [CW-1:0] t;
    row_hit = '0;
    t       = '0;
    if (active[pend_idx]) begin
      for (int k = 0; k < SLOTS_PER_STATE; k++) begin
        t = CW'(row_rd[k].tgt);
        for (int j = 0; j < MAX_STATES; j++) begin
          if (row_rd[k].en && (row_rd[k].sym == char_r) && (t < n_used) && (t == CW'(j))) begin
            row_hit[j] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    ram_raddr = node_ext[AW-1:0];
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_LOAD: begin
        ram_we    = 1'b1;
        ram_waddr = node_r;
        ram_wdata = row_wr;
      end
      S_FEED: begin
        ram_raddr = feed_idx[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  nsr_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_STATES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      states_in_use <= STATES_RESET;
      active        <= MAX_STATES'(1);
      char_count    <= '0;
      clr_idx       <= '0;
      feed_idx      <= '0;
      pend          <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        states_in_use <= cfg_data;
      end
      // S_DONE drives result_valid itself
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(MAX_STATES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            node_r      <= node_ext[AW-1:0];
            slot_r      <= slot_ext[SW-1:0];
            entry_r.en  <= entry_valid;
            entry_r.sym <= entry_symbol;
            entry_r.tgt <= entry_target;
            char_r      <= character;
            feed_idx    <= '0;
            pend        <= 1'b0;
            acc         <= '0;
            case (action)
              ACT_LOAD: begin
                state <= load_ok ? S_LOAD : S_DONE;
              end
              ACT_START: begin
                active     <= MAX_STATES'(1);
                char_count <= '0;
                state      <= S_DONE;
              end
              ACT_FEED: begin
                state <= S_FEED;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_LOAD: begin
          state <= S_DONE;
        end
        S_FEED: begin
          // read row feed_idx while row pend_idx arrives from the RAM
          if (feed_idx < n_used) begin
            pend     <= 1'b1;
            pend_idx <= feed_idx[AW-1:0];
            feed_idx <= feed_idx + CW'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            acc <= acc | row_hit;
          end
          if (!pend && (feed_idx == n_used)) begin
            active <= acc;
            if (char_count != POSITION_MAX) begin
              char_count <= char_count + POS_W'(1);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            accepted     <= live[n_last[AW-1:0]];
            alive        <= (live != '0);
            position     <= char_count;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/nsr_checker.sv
// ----------------------------------------------------------------------------
// NFA recognizer checker
// Port-level checks on reset, sequencing and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nsr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic                      accepted,
  input logic                      alive,
  input logic [nsr_pkg::POS_W-1:0] position
);

  // reset leaves no result pending and starts the table clearing pass
  `ASSERT_ALWAYS(a_rst_no_result, clk, $past(rst), !result_valid)
  `ASSERT_ALWAYS(a_rst_clearing, clk, $past(rst), item_stall)

  // one transaction at a time: a taken item closes the input side
  `ASSERT_NEXT(a_one_item, clk, rst, item_valid && !item_stall, item_stall)

  // the accepting state is one of the live states
  `ASSERT_IMPLY(a_acc_alive, clk, rst, result_valid && accepted, alive)

  // a stalled result holds
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(position) && $stable(accepted) && $stable(alive))

endmodule

bind nfa_string_recognizer nsr_checker u_nsr_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .accepted    (accepted),
  .alive       (alive),
  .position    (position)
);

// File: verif/tb_nfa_string_recognizer.sv
// ----------------------------------------------------------------------------
// NFA string recognizer testbench
// Drives loads, starts and characters through the item channel and keeps a
// local model of the transition table, the active set and the position. Each
// result transaction is checked against the oldest pending status. Covers
// directed corner cases, selected state counts (out-of-range ones included),
// backpressure and random automata with random strings.
// ----------------------------------------------------------------------------
module tb_nfa_string_recognizer;
  timeunit 1ns;
  timeprecision 1ps;

  import nsr_pkg::*;

  localparam int NUM_STATES = 32;
  localparam int NUM_SLOTS = 8;
  localparam int TABLE_DEPTH = NUM_STATES * NUM_SLOTS;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [7:0] CHAIN_SYM = 8'h63;
  localparam int SETTLE_CYCLES = NUM_STATES + 8;
  localparam longint TIMEOUT_NS = 30_000_000;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] node;
    logic [2:0] slot;
    logic [7:0] entry_symbol;
    logic [4:0] entry_target;
    logic       entry_valid;
    logic [7:0] character;
  } nfa_item_t;

  typedef struct packed {
    logic             accepted;
    logic             alive;
    logic [POS_W-1:0] position;
  } nfa_status_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  logic             item_valid;
  logic             item_stall;
  logic [1:0]       action;
  logic [4:0]       node;
  logic [2:0]       slot;
  logic [7:0]       entry_symbol;
  logic [4:0]       entry_target;
  logic             entry_valid;
  logic [7:0]       character;
  logic             result_valid;
  logic             result_stall;
  logic             accepted;
  logic             alive;
  logic [POS_W-1:0] position;

  // local copy of the automaton
  logic [7:0]            sym_tab [TABLE_DEPTH];
  logic [4:0]            tgt_tab [TABLE_DEPTH];
  bit                    en_tab  [TABLE_DEPTH];
  logic [NUM_STATES-1:0] live_set;
  logic [POS_W-1:0]      pos_count;
  logic [CFG_W-1:0]      states_cfg;

  nfa_status_t pending_status [$];
  int unsigned items_sent;
  int unsigned error_count;
  bit          tx_gaps;
  bit          rx_gaps;
  int unsigned hold_req;

  nfa_string_recognizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .node         (node),
    .slot         (slot),
    .entry_symbol (entry_symbol),
    .entry_target (entry_target),
    .entry_valid  (entry_valid),
    .character    (character),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted),
    .alive        (alive),
    .position     (position)
  );

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned idle_length();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(12, 48);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic nfa_item_t random_item(logic [1:0] act);
    nfa_item_t it;
    it = nfa_item_t'($urandom);
    it.action = act;
    return it;
  endfunction

  // applies one transaction to the local automaton and returns its status
  function automatic nfa_status_t advance_automaton(nfa_item_t it);
    int                    used;
    int                    e;
    logic [NUM_STATES-1:0] next_set;
    logic [NUM_STATES-1:0] live;
    nfa_status_t           st;
    used = (states_cfg == 0) ? 1 : (states_cfg > NUM_STATES) ? NUM_STATES : int'(states_cfg);
    case (it.action)
      ACT_LOAD: begin
        e = it.node * NUM_SLOTS + it.slot;
        sym_tab[e] = it.entry_symbol;
        tgt_tab[e] = it.entry_target;
        en_tab[e] = it.entry_valid;
      end
      ACT_START: begin
        live_set = 1;
        pos_count = '0;
      end
      ACT_FEED: begin
        next_set = '0;
        for (int s = 0; s < used; s++) begin
          if (live_set[s]) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
              e = s * NUM_SLOTS + k;
              if (en_tab[e] && sym_tab[e] == it.character && tgt_tab[e] < used) begin
                next_set[tgt_tab[e]] = 1'b1;
              end
            end
          end
        end
        // the next set holds only targets below the count; the output is masked too
        live_set = next_set;
        if (pos_count != POSITION_MAX) begin
          pos_count = pos_count + 1'b1;
        end
      end
      default: ;
    endcase
    live = live_set & ({NUM_STATES{1'b1}} >> (NUM_STATES - used));
    st.accepted = live[used-1];
    st.alive = |live;
    st.position = pos_count;
    return st;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_item(nfa_item_t it);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= it.action;
    node <= it.node;
    slot <= it.slot;
    entry_symbol <= it.entry_symbol;
    entry_target <= it.entry_target;
    entry_valid <= it.entry_valid;
    character <= it.character;
    do @(posedge clk); while (item_stall);
    pending_status.push_back(advance_automaton(it));
    items_sent++;
  endtask

  task automatic load_entry(int node_id, int slot_id, logic [7:0] sym, logic [4:0] tgt,
                            bit en);
    nfa_item_t it;
    it = random_item(ACT_LOAD);
    it.node = 5'(node_id);
    it.slot = 3'(slot_id);
    it.entry_symbol = sym;
    it.entry_target = tgt;
    it.entry_valid = en;
    send_item(it);
  endtask

  task automatic start_string();
    send_item(random_item(ACT_START));
  endtask

  task automatic feed_char(logic [7:0] ch);
    nfa_item_t it;
    it = random_item(ACT_FEED);
    it.character = ch;
    send_item(it);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_states(logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    states_cfg = value;
  endtask

  task automatic test_directed_cases();
    nfa_item_t all_ones;
    all_ones = '1;
    wait_idle();
    write_states(6'd2);
    send_item(random_item(ACT_UNUSED));
    load_entry(0, 0, 8'h00, 5'd1, 1'b1);
    load_entry(31, 7, 8'hFF, 5'd31, 1'b1);
    load_entry(0, 7, 8'hFF, 5'd0, 1'b1);
    load_entry(1, 3, 8'hAA, 5'd5, 1'b1);  // target outside the states in use
    start_string();
    feed_char(8'h00);
    feed_char(8'hAA);
    feed_char(8'h55);  // dead set, position still moves
    start_string();
    feed_char(8'hFF);
    load_entry(0, 0, 8'h00, 5'd1, 1'b0);
    feed_char(8'h00);
    send_item(all_ones);
  endtask

  // chain of states walked for each count, out-of-range counts included
  task automatic test_state_counts();
    logic [CFG_W-1:0] counts [7] = '{6'd0, 6'd1, 6'd2, 6'd31, 6'd32, 6'd33, 6'd63};
    int               len;
    wait_idle();
    for (int s = 0; s < NUM_STATES; s++) begin
      load_entry(s, 6, CHAIN_SYM, 5'(s + 1), 1'b1);
    end
    foreach (counts[i]) begin
      wait_idle();
      write_states(counts[i]);
      len = (counts[i] == 0) ? 2 : (counts[i] > NUM_STATES) ? NUM_STATES + 1 : counts[i] + 1;
      feed_char(CHAIN_SYM);  // set left from the previous count
      start_string();
      repeat (len) feed_char(CHAIN_SYM);
    end
  endtask

  task automatic test_stall_pressure();
    wait_idle();
    write_states(6'd4);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_req = 300;
    start_string();
    repeat (20) feed_char(8'($urandom));
    wait_idle();
    start_string();
    repeat (5) feed_char(CHAIN_SYM);
  endtask

  task automatic test_random_strings(int unsigned target);
    logic [7:0]  alphabet [4];
    int unsigned first_count;
    int          count;
    int unsigned pick;
    first_count = items_sent;
    while (items_sent - first_count < target) begin
      wait_idle();
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 19);
      count = (pick < 14) ? $urandom_range(2, 8) : (pick < 17) ? $urandom_range(9, 31) : NUM_STATES;
      write_states(CFG_W'(count));
      foreach (alphabet[i]) alphabet[i] = 8'($urandom);
      for (int s = 0; s < count; s++) begin
        repeat ($urandom_range(1, 3)) begin
          load_entry(s, $urandom_range(0, NUM_SLOTS - 1), alphabet[$urandom_range(0, 3)],
                     5'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, count - 1)),
                     $urandom_range(0, 9) != 0);
        end
      end
      repeat ($urandom_range(3, 8)) begin
        start_string();
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 19))
            0: send_item(random_item(ACT_UNUSED));
            1: send_item(random_item(ACT_LOAD));
            2: feed_char(8'($urandom));
            default: feed_char(alphabet[$urandom_range(0, 3)]);
          endcase
        end
      end
    end
  endtask

  initial begin : result_receiver
    int unsigned len;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        len = hold_req;
        hold_req = 0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        len = idle_length();
      end else begin
        len = 0;
      end
      if (len != 0) begin
        result_stall <= 1'b1;
        repeat (len) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : status_checker
    nfa_status_t want;
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result with no transaction pending", position, 0);
      end else begin
        want = pending_status.pop_front();
        if (accepted !== want.accepted) report_mismatch("accepted", accepted, want.accepted);
        if (alive !== want.alive) report_mismatch("alive", alive, want.alive);
        if (position !== want.position) report_mismatch("position", position, want.position);
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    item_valid <= 1'b0;
    action <= ACT_START;
    node <= '0;
    slot <= '0;
    entry_symbol <= '0;
    entry_target <= '0;
    entry_valid <= 1'b0;
    character <= '0;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_req = 0;
    items_sent = 0;
    error_count = 0;
    foreach (en_tab[i]) begin
      en_tab[i] = 1'b0;
      sym_tab[i] = '0;
      tgt_tab[i] = '0;
    end
    live_set = 1;
    pos_count = '0;
    states_cfg = STATES_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_state_counts();
    test_stall_pressure();
    test_random_strings(1350);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
